@@ hdl/pptp_pkg.sv @@
package pptp_pkg;

   localparam int VALUE_BITS_DEFAULT = 32;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_OPEN  = 8'h28;
   localparam logic [7:0] CH_CLOSE = 8'h29;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_COMMA = 8'h2c;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   typedef enum logic [3:0] {
      PH_LEAD   = 4'd0,
      PH_WS1    = 4'd1,
      PH_SIGN1  = 4'd2,
      PH_DIG1   = 4'd3,
      PH_AFTER1 = 4'd4,
      PH_WS2    = 4'd5,
      PH_SIGN2  = 4'd6,
      PH_DIG2   = 4'd7,
      PH_AFTER2 = 4'd8,
      PH_DONE   = 4'd9,
      PH_FAIL   = 4'd10
   } phase_type;

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB);
   endfunction

   function automatic logic is_cspace(input logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

endpackage

@@ hdl/point_pair_text_parser.sv @@
// channel  | ports                                      | direction
// req      | req_valid, req_stall, req_char_code,       | in (stall out)
//          | req_last_char                              |
// rsp      | rsp_valid, rsp_stall, rsp_parse_ok,        | out (stall in)
//          | rsp_x_value, rsp_y_value                   |
//
// One character per clock while req_stall is low; each character updates the parse state.
// The result of the character marked last is registered in the output register,
// or in the skid register while the output register holds a stalled result.
// Reset is synchronous and returns the parser to the leading-blank phase.
// Two result registers (output and skid) absorb one more result while rsp
// stalls; req_stall rises only when both hold a result.
module point_pair_text_parser #(
   parameter int VALUE_BITS = pptp_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [7:0]                   req_char_code,
   input  logic                         req_last_char,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_parse_ok,
   output logic signed [VALUE_BITS-1:0] rsp_x_value,
   output logic signed [VALUE_BITS-1:0] rsp_y_value
);
   import pptp_pkg::*;

   logic                         step_valid;
   logic                         new_valid;
   logic                         new_ok;
   logic signed [VALUE_BITS-1:0] new_x;
   logic signed [VALUE_BITS-1:0] new_y;
   logic                         take;

   logic                         out_valid_ff, out_valid_in;
   logic                         out_ok_ff, out_ok_in;
   logic signed [VALUE_BITS-1:0] out_x_ff, out_x_in;
   logic signed [VALUE_BITS-1:0] out_y_ff, out_y_in;
   logic                         skid_valid_ff, skid_valid_in;
   logic                         skid_ok_ff, skid_ok_in;
   logic signed [VALUE_BITS-1:0] skid_x_ff, skid_x_in;
   logic signed [VALUE_BITS-1:0] skid_y_ff, skid_y_in;

   assign req_stall  = skid_valid_ff;
   assign step_valid = req_valid & ~req_stall;
   assign take       = out_valid_ff & ~rsp_stall;

   pptp_parse_core #(
      .VALUE_BITS (VALUE_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step_valid (step_valid),
      .char_code  (req_char_code),
      .last_char  (req_last_char),
      .res_valid  (new_valid),
      .res_ok     (new_ok),
      .res_x      (new_x),
      .res_y      (new_y)
   );

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_ok_in     = out_ok_ff;
      out_x_in      = out_x_ff;
      out_y_in      = out_y_ff;
      skid_valid_in = skid_valid_ff;
      skid_ok_in    = skid_ok_ff;
      skid_x_in     = skid_x_ff;
      skid_y_in     = skid_y_ff;
      if (~out_valid_ff | take) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_ok_in     = skid_ok_ff;
            out_x_in      = skid_x_ff;
            out_y_in      = skid_y_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = new_valid;
            out_ok_in    = new_ok;
            out_x_in     = new_x;
            out_y_in     = new_y;
         end
      end else if (new_valid) begin
         skid_valid_in = 1'b1;
         skid_ok_in    = new_ok;
         skid_x_in     = new_x;
         skid_y_in     = new_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ok_ff  <= out_ok_in;
      out_x_ff   <= out_x_in;
      out_y_ff   <= out_y_in;
      skid_ok_ff <= skid_ok_in;
      skid_x_ff  <= skid_x_in;
      skid_y_ff  <= skid_y_in;
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_parse_ok = out_ok_ff;
   assign rsp_x_value  = out_x_ff;
   assign rsp_y_value  = out_y_ff;

`ifndef SYNTHESIS
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a result while the output register is empty");

   a_skid_fill_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(out_valid_ff & rsp_stall))
      else $error("skid filled without a stalled output");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff & ~out_ok_ff) |-> (out_x_ff == '0 && out_y_ff == '0))
      else $error("failed parse carries nonzero values");
`endif

endmodule

@@ hdl/pptp_parse_core.sv @@
module pptp_parse_core #(
   parameter int VALUE_BITS = pptp_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step_valid,
   input  logic [7:0]                   char_code,
   input  logic                         last_char,
   output logic                         res_valid,
   output logic                         res_ok,
   output logic signed [VALUE_BITS-1:0] res_x,
   output logic signed [VALUE_BITS-1:0] res_y
);
   import pptp_pkg::*;

   localparam int WIDE = VALUE_BITS + 4;
   localparam logic [VALUE_BITS-1:0] LIM = {1'b1, {(VALUE_BITS-1){1'b0}}};
   localparam logic [VALUE_BITS-1:0] MAX_POS = LIM - 1'b1;

   phase_type             phase_ff, phase_nx, phase_in;
   logic [VALUE_BITS-1:0] mag_ff, mag_nx, mag_in;
   logic                  neg_ff, neg_nx, neg_in;
   logic [VALUE_BITS-1:0] first_ff, first_nx, first_in;
   logic [3:0]            dig;
   logic [WIDE-1:0]       prod;
   logic [VALUE_BITS-1:0] mag_add;

   function automatic logic [VALUE_BITS-1:0] cur_value(
      input logic [VALUE_BITS-1:0] m,
      input logic                  n
   );
      logic [VALUE_BITS-1:0] r;
      if (n) begin
         r = -m;
      end else if (m > MAX_POS) begin
         r = MAX_POS;
      end else begin
         r = m;
      end
      return r;
   endfunction

   always_comb begin
      dig  = 4'(char_code - CH_ZERO);
      prod = ({4'b0, mag_ff} << 3) + ({4'b0, mag_ff} << 1) + WIDE'(dig);
      if (prod > {4'b0, LIM}) begin
         mag_add = LIM;
      end else begin
         mag_add = prod[VALUE_BITS-1:0];
      end
   end

   always_comb begin
      phase_nx = phase_ff;
      mag_nx   = mag_ff;
      neg_nx   = neg_ff;
      first_nx = first_ff;
      if (step_valid) begin
         unique case (phase_ff)
            PH_LEAD: begin
               if (is_blank(char_code)) begin
                  phase_nx = PH_LEAD;
               end else if (char_code == CH_OPEN) begin
                  mag_nx   = '0;
                  neg_nx   = 1'b0;
                  phase_nx = PH_WS1;
               end else begin
                  phase_nx = PH_FAIL;
               end
            end
            PH_WS1, PH_WS2: begin
               if (is_cspace(char_code)) begin
                  phase_nx = phase_ff;
               end else if (char_code == CH_PLUS || char_code == CH_MINUS) begin
                  neg_nx   = (char_code == CH_MINUS);
                  phase_nx = (phase_ff == PH_WS1) ? PH_SIGN1 : PH_SIGN2;
               end else if (is_digit(char_code)) begin
                  mag_nx   = mag_add;
                  phase_nx = (phase_ff == PH_WS1) ? PH_DIG1 : PH_DIG2;
               end else begin
                  phase_nx = PH_FAIL;
               end
            end
            PH_SIGN1, PH_SIGN2: begin
               if (is_digit(char_code)) begin
                  mag_nx   = mag_add;
                  phase_nx = (phase_ff == PH_SIGN1) ? PH_DIG1 : PH_DIG2;
               end else begin
                  phase_nx = PH_FAIL;
               end
            end
            PH_DIG1, PH_AFTER1: begin
               if (phase_ff == PH_DIG1 && is_digit(char_code)) begin
                  mag_nx = mag_add;
               end else if (is_blank(char_code)) begin
                  phase_nx = PH_AFTER1;
               end else if (char_code == CH_COMMA) begin
                  first_nx = cur_value(mag_ff, neg_ff);
                  mag_nx   = '0;
                  neg_nx   = 1'b0;
                  phase_nx = PH_WS2;
               end else begin
                  phase_nx = PH_FAIL;
               end
            end
            PH_DIG2, PH_AFTER2: begin
               if (phase_ff == PH_DIG2 && is_digit(char_code)) begin
                  mag_nx = mag_add;
               end else if (is_blank(char_code)) begin
                  phase_nx = PH_AFTER2;
               end else if (char_code == CH_CLOSE) begin
                  phase_nx = PH_DONE;
               end else begin
                  phase_nx = PH_FAIL;
               end
            end
            PH_DONE: begin
               phase_nx = PH_DONE;
            end
            default: begin
               phase_nx = PH_FAIL;
            end
         endcase
      end

      res_valid = step_valid & last_char;
      res_ok    = (phase_nx == PH_DONE);
      res_x     = res_ok ? first_nx : '0;
      res_y     = res_ok ? cur_value(mag_nx, neg_nx) : '0;

      if (res_valid) begin
         phase_in = PH_LEAD;
         mag_in   = '0;
         neg_in   = 1'b0;
         first_in = '0;
      end else begin
         phase_in = phase_nx;
         mag_in   = mag_nx;
         neg_in   = neg_nx;
         first_in = first_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LEAD;
         mag_ff   <= '0;
         neg_ff   <= 1'b0;
         first_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         mag_ff   <= mag_in;
         neg_ff   <= neg_in;
         first_ff <= first_in;
      end
   end

endmodule

@@ test/tb_point_pair_text_parser.sv @@
module tb_point_pair_text_parser;
   timeunit 1ns;
   timeprecision 1ps;

   import pptp_pkg::*;

   localparam int VALUE_BITS = VALUE_BITS_DEFAULT;
   localparam longint unsigned MAG_LIMIT = 64'd1 << (VALUE_BITS - 1);
   localparam logic [7:0] CH_LF = 8'h0a;
   localparam logic [7:0] CH_VT = 8'h0b;
   localparam logic [7:0] CH_FF = 8'h0c;
   localparam int TEXT_CHARS = 1900;
   localparam int QUIET_CHARS = 1700;

   typedef struct {
      logic                         parse_ok;
      logic signed [VALUE_BITS-1:0] x_value;
      logic signed [VALUE_BITS-1:0] y_value;
   } point_result_type;

   class point_scoreboard;
      phase_type       phase;
      longint unsigned magnitude;
      bit              negative;
      logic [VALUE_BITS-1:0] first_value;
      point_result_type expected_points[$];
      int              errors;

      function new();
         clear_parse();
         errors = 0;
      endfunction

      function void clear_parse();
         phase = PH_LEAD;
         magnitude = 0;
         negative = 1'b0;
         first_value = '0;
      endfunction

      function int pending();
         return expected_points.size();
      endfunction

      function bit blank_char(input logic [7:0] c);
         return c == CH_SPACE || c == CH_TAB;
      endfunction

      function bit space_char(input logic [7:0] c);
         return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
      endfunction

      function bit digit_char(input logic [7:0] c);
         return c >= CH_ZERO && c <= CH_NINE;
      endfunction

      function void start_number();
         magnitude = 0;
         negative = 1'b0;
      endfunction

      function void add_digit(input logic [7:0] c);
         longint unsigned d;
         d = longint'(c - CH_ZERO);
         if (magnitude > (MAG_LIMIT - d) / 10) magnitude = MAG_LIMIT;
         else magnitude = magnitude * 10 + d;
      endfunction

      function logic [VALUE_BITS-1:0] saturated_value();
         longint unsigned m;
         longint unsigned r;
         m = magnitude;
         if (negative) begin
            if (m > MAG_LIMIT) m = MAG_LIMIT;
            r = 64'd0 - m;
         end else begin
            if (m > MAG_LIMIT - 1) m = MAG_LIMIT - 1;
            r = m;
         end
         return r[VALUE_BITS-1:0];
      endfunction

      function phase_type begin_number(input logic [7:0] c, input phase_type sign_phase,
                                       input phase_type digit_phase, input phase_type hold);
         if (space_char(c)) return hold;
         if (c == CH_PLUS || c == CH_MINUS) begin
            negative = (c == CH_MINUS);
            return sign_phase;
         end
         if (digit_char(c)) begin
            add_digit(c);
            return digit_phase;
         end
         return PH_FAIL;
      endfunction

      function void step_char(input logic [7:0] c);
         case (phase)
            PH_LEAD: begin
               if (!blank_char(c)) begin
                  if (c == CH_OPEN) begin
                     start_number();
                     phase = PH_WS1;
                  end else phase = PH_FAIL;
               end
            end
            PH_WS1: phase = begin_number(c, PH_SIGN1, PH_DIG1, PH_WS1);
            PH_WS2: phase = begin_number(c, PH_SIGN2, PH_DIG2, PH_WS2);
            PH_SIGN1, PH_SIGN2: begin
               if (digit_char(c)) begin
                  add_digit(c);
                  phase = (phase == PH_SIGN1) ? PH_DIG1 : PH_DIG2;
               end else phase = PH_FAIL;
            end
            PH_DIG1, PH_AFTER1: begin
               if (phase == PH_DIG1 && digit_char(c)) add_digit(c);
               else if (blank_char(c)) phase = PH_AFTER1;
               else if (c == CH_COMMA) begin
                  first_value = saturated_value();
                  start_number();
                  phase = PH_WS2;
               end else phase = PH_FAIL;
            end
            PH_DIG2, PH_AFTER2: begin
               if (phase == PH_DIG2 && digit_char(c)) add_digit(c);
               else if (blank_char(c)) phase = PH_AFTER2;
               else phase = (c == CH_CLOSE) ? PH_DONE : PH_FAIL;
            end
            PH_DONE: ;
            default: phase = PH_FAIL;
         endcase
      endfunction

      function void note_char(input logic [7:0] c, input logic last);
         point_result_type p;
         step_char(c);
         if (last) begin
            p.parse_ok = (phase == PH_DONE);
            p.x_value = p.parse_ok ? first_value : '0;
            p.y_value = p.parse_ok ? saturated_value() : '0;
            expected_points.push_back(p);
            clear_parse();
         end
      endfunction

      function void check_point(input logic ok, input logic signed [VALUE_BITS-1:0] x,
                                input logic signed [VALUE_BITS-1:0] y);
         point_result_type p;
         if (expected_points.size() == 0) begin
            $error("result with none expected: parse_ok %0d x %0d y %0d", ok, x, y);
            errors++;
            return;
         end
         p = expected_points.pop_front();
         if (ok !== p.parse_ok) begin
            $error("parse_ok: expected %0d, actual %0d", p.parse_ok, ok);
            errors++;
         end
         if (x !== p.x_value) begin
            $error("x_value: expected %0d, actual %0d", p.x_value, x);
            errors++;
         end
         if (y !== p.y_value) begin
            $error("y_value: expected %0d, actual %0d", p.y_value, y);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [7:0] req_char_code = '0;
   logic req_last_char = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_parse_ok;
   logic signed [VALUE_BITS-1:0] rsp_x_value;
   logic signed [VALUE_BITS-1:0] rsp_y_value;

   point_scoreboard parse_sb = new();
   logic [7:0] text_buf[$];
   int sent_chars = 0;
   int idle_pct = 0;
   int stall_pct = 0;
   int stall_left = 0;

   always #2 clock = ~clock;

   point_pair_text_parser #(.VALUE_BITS(VALUE_BITS)) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_char_code(req_char_code),
      .req_last_char(req_last_char),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_parse_ok(rsp_parse_ok),
      .rsp_x_value(rsp_x_value),
      .rsp_y_value(rsp_y_value)
   );

   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 99) < stall_pct) begin
         stall_left <= $urandom_range(0, 17);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         parse_sb.check_point(rsp_parse_ok, rsp_x_value, rsp_y_value);
   end

   task automatic send_char(input logic [7:0] c, input logic last);
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_char_code <= c;
      req_last_char <= last;
      do @(posedge clock); while (req_stall);
      parse_sb.note_char(c, last);
      sent_chars++;
   endtask

   task automatic send_text();
      for (int i = 0; i < text_buf.size(); i++)
         send_char(text_buf[i], i == text_buf.size() - 1);
      text_buf.delete();
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
   endtask

   task automatic push_blanks();
      if ($urandom_range(0, 2) == 0)
         repeat ($urandom_range(1, 3)) text_buf.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
   endtask

   task automatic push_spaces();
      logic [7:0] c;
      if ($urandom_range(0, 2) == 0) begin
         repeat ($urandom_range(1, 3)) begin
            c = $urandom_range(0, 1) ? CH_SPACE : 8'($urandom_range(CH_TAB, CH_CR));
            text_buf.push_back(c);
         end
      end
   endtask

   task automatic push_number();
      int sel;
      int digits;
      sel = $urandom_range(0, 2);
      if (sel == 1) text_buf.push_back(CH_PLUS);
      else if (sel == 2) text_buf.push_back(CH_MINUS);
      sel = $urandom_range(0, 19);
      if (sel == 0) begin
         push_text("214748364");
         text_buf.push_back(8'(CH_ZERO + $urandom_range(6, 9)));
         return;
      end
      if (sel < 12) digits = $urandom_range(1, 3);
      else if (sel < 18) digits = $urandom_range(4, 10);
      else digits = $urandom_range(11, 20);
      repeat (digits) text_buf.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
   endtask

   task automatic build_random_text();
      int sel;
      int pos;
      if ($urandom_range(0, 7) == 0) begin
         repeat ($urandom_range(1, 6)) text_buf.push_back(8'($urandom_range(0, 255)));
         return;
      end
      push_blanks();
      text_buf.push_back(CH_OPEN);
      push_spaces();
      push_number();
      push_blanks();
      text_buf.push_back(CH_COMMA);
      push_spaces();
      push_number();
      push_blanks();
      text_buf.push_back(CH_CLOSE);
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 4)) text_buf.push_back(8'($urandom_range(0, 255)));
      sel = $urandom_range(0, 9);
      pos = $urandom_range(0, text_buf.size() - 1);
      case (sel)
         0: text_buf[pos] = 8'($urandom_range(0, 255));
         1: text_buf = text_buf[0:pos];
         2: text_buf.insert(pos, $urandom_range(0, 1) ? CH_NUL : 8'($urandom_range(0, 255)));
         default: ;
      endcase
   endtask

   initial begin
      int strings;
      bit drained;
      strings = 0;
      drained = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      push_text("(1, 2)"); send_text();
      push_text(" \t( -2147483648 ,\t+2147483647 \t)"); send_text();
      push_text("(-99999999999999999999,99999999999999999999)"); send_text();
      text_buf.push_back(CH_OPEN);
      text_buf.push_back(CH_LF);
      text_buf.push_back(CH_VT);
      text_buf.push_back(CH_FF);
      text_buf.push_back(CH_CR);
      push_text("5,");
      text_buf.push_back(CH_CR);
      push_text("-0)");
      send_text();
      push_text("(2147483648,-2147483649)"); send_text();
      push_text("(0,0)xyz"); text_buf.push_back(8'hff); send_text();
      push_text("(3,4)"); text_buf.push_back(CH_NUL); push_text("9"); send_text();
      push_text("(1"); text_buf.push_back(CH_NUL); push_text(",2)"); send_text();
      push_text("(+,1)"); send_text();
      push_text("(1 2,3)"); send_text();
      push_text("(1,2"); send_text();
      push_text("x"); send_text();
      push_text("("); send_text();
      push_text("(1 ,  -7 )"); send_text();
      text_buf.push_back(CH_LF); push_text("(1,2)"); send_text();
      push_text("(1,2"); text_buf.push_back(CH_LF); push_text(")"); send_text();
      push_text("(- 5,1)"); send_text();
      push_text("(,1)"); send_text();
      text_buf.push_back(8'h80); send_text();
      push_text("(007,+00)"); send_text();

      while (sent_chars < TEXT_CHARS) begin
         if (strings % 10 == 0) begin
            case ($urandom_range(0, 3))
               0: idle_pct = 0;
               1: idle_pct = 5;
               2: idle_pct = 20;
               default: idle_pct = 50;
            endcase
            case ($urandom_range(0, 3))
               0: stall_pct = 0;
               1: stall_pct = 5;
               2: stall_pct = 15;
               default: stall_pct = 40;
            endcase
         end
         if (sent_chars >= QUIET_CHARS) begin
            idle_pct = 0;
            stall_pct = 0;
         end
         if (!drained && sent_chars >= TEXT_CHARS / 2) begin
            drained = 1'b1;
            req_valid <= 1'b0;
            while (parse_sb.pending() != 0) @(posedge clock);
            repeat (4) @(posedge clock);
         end
         build_random_text();
         send_text();
         strings++;
      end

      req_valid <= 1'b0;
      while (parse_sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (parse_sb.errors == 0 && parse_sb.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("simulation failed");
      $finish;
   end
endmodule

@@ sim.f @@
hdl/pptp_pkg.sv
hdl/pptp_parse_core.sv
hdl/point_pair_text_parser.sv
test/tb_point_pair_text_parser.sv
